// File: src/mste_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mste_pkg;
   localparam int SLOTS_DEF = 16;
   localparam int TARGET_BITS_DEF = 8;
   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam logic [16:0] HALF_Q16 = 17'h08000;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_CANCEL = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   localparam logic [2:0] ST_STARTED = 3'd0;
   localparam logic [2:0] ST_IMMEDIATE = 3'd1;
   localparam logic [2:0] ST_NO_CAP = 3'd2;
   localparam logic [2:0] ST_CANCELLED = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_TICK_UPD = 3'd5;
   localparam logic [2:0] ST_TICK_IDLE = 3'd6;

   // divider request and answer
   typedef struct packed {
      logic        start;
      logic [16:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// File: src/mste_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mste_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mste_pkg::div_req_type req,
   output mste_pkg::div_rsp_type      rsp
);
   logic [16:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   // shift in one dividend bit and try a subtract
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[16]} - {2'b00, dvs_ff};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[16]};
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// File: src/multi_slot_tween_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Multi-slot tween engine.
// Input channel req_*: an item is taken when req_valid is high and req_stall low.
// Actions: start (claim slot by target, else lowest free), cancel, tick.
// Results rsp_*: one or more per start, cancel or tick; rsp_last marks the final.
// A start scans the slots one per cycle and then runs the 17-step divider
// for the Q16 step. A cancel is answered once the scan is done.
// A tick visits the slots in index order, stopping after the last active
// one; each active slot goes through advance, ease square, delta times
// ease, add and hand over.
// The block takes no new item until the last result of the current one has
// been handed over. A stall on rsp holds the result register, and the
// sequencer waits for it before it hands over a new result. Reset clears
// all slots inactive and idles the sequencer; slot storage needs no clearing.
module multi_slot_tween_engine #(
   parameter int SLOTS = mste_pkg::SLOTS_DEF,
   parameter int TARGET_BITS = mste_pkg::TARGET_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic [7:0]         req_target_id,
   input  wire logic signed [31:0] req_start_value,
   input  wire logic signed [31:0] req_end_value,
   input  wire logic [15:0]        req_duration,
   input  wire logic               req_ease_mode,
   input  wire logic               req_notify_done,
   input  wire logic               req_snap,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_target,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_write_valid,
   output logic                    rsp_done_event,
   output logic [3:0]              rsp_slot_index,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   // target ids are 8 bits wide on the ports
   localparam int TB = (TARGET_BITS > 8) ? 8 : TARGET_BITS;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SCAN  = 9'b000000010,
      S_DIV   = 9'b000000100,
      S_VISIT = 9'b000001000,
      S_SQ    = 9'b000010000,
      S_MUL   = 9'b000100000,
      S_ADD   = 9'b001000000,
      S_EMIT  = 9'b010000000,
      S_WAIT  = 9'b100000000
   } state_type;

   state_type   state_ff;

   // slot storage
   logic [SLOTS-1:0] active_ff;
   logic [TB-1:0] tgt_mem [SLOTS];
   logic [31:0]   start_mem [SLOTS];
   logic [31:0]   end_mem [SLOTS];
   logic [31:0]   delta_mem [SLOTS];
   logic          ease_mem [SLOTS];
   logic          notify_mem [SLOTS];
   logic [16:0]   prog_mem [SLOTS];
   logic [16:0]   step_mem [SLOTS];

   // latched item
   logic [1:0]  act_ff;
   logic [TB-1:0] tgt_ff;
   logic [31:0] sv_ff, ev_ff;
   logic [15:0] dur_ff;
   logic        ease_ff, notify_ff, snap_ff;

   logic [IW:0] idx_ff;
   logic [IW-1:0] slot;
   logic        hit_ff, free_ff, any_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff;

   // per-slot working registers
   logic [16:0] p_ff;
   logic [16:0] e_ff;
   logic signed [63:0] prod_ff;
   logic        sq_hi_ff;

   // result register
   logic        out_v_ff;
   logic [7:0]  o_tgt_ff;
   logic [31:0] o_val_ff;
   logic        o_wv_ff, o_done_ff, o_last_ff;
   logic [3:0]  o_slot_ff;
   logic [2:0]  o_st_ff;

   logic        div_go_ff;

   mste_pkg::div_req_type dreq;
   mste_pkg::div_rsp_type drsp;

   mste_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic accept;
   logic out_free;
   logic emit_now;
   assign accept = req_valid && !req_stall;
   assign out_free = !out_v_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || out_v_ff;
   assign slot = idx_ff[IW-1:0];

   // shared multiplier operands
   logic [16:0] pm;
   logic [16:0] sq_op;
   logic [33:0] sq_res;
   logic [16:0] sq_q;
   logic [16:0] ease_v;
   assign pm = mste_pkg::ONE_Q16 - p_ff;
   assign sq_op = (p_ff <= mste_pkg::HALF_Q16) ? p_ff : pm;
   assign sq_res = sq_op * sq_op;
   assign sq_q = {sq_res[31:16], 1'b0};

   always_comb begin
      if (sq_hi_ff) begin
         ease_v = (e_ff >= mste_pkg::ONE_Q16) ? 17'd0 : mste_pkg::ONE_Q16 - e_ff;
      end else begin
         ease_v = (e_ff > mste_pkg::ONE_Q16) ? mste_pkg::ONE_Q16 : e_ff;
      end
   end

   logic last_slot;
   assign last_slot = (idx_ff == (IW+1)'(SLOTS - 1));

   // find any active slot above the current one
   logic later_act;
   always_comb begin
      later_act = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
         if (k > int'(slot) && active_ff[k]) later_act = 1'b1;
      end
   end

   // hand a result to the output register
   always_comb begin
      emit_now = out_free && ((state_ff == S_EMIT) ||
                 ((state_ff == S_DIV) && ((act_ff == mste_pkg::ACT_CANCEL) ||
                  (!hit_ff && !free_ff) || (dur_ff == 16'd0))));
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (emit_now) begin
         out_v_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_v_ff <= 1'b0;
      end
   end

   // launch the divider once per claimed start
   always_ff @(posedge clock) begin
      if (reset) begin
         div_go_ff <= 1'b0;
      end else begin
         div_go_ff <= (state_ff == S_DIV) && (act_ff == mste_pkg::ACT_START) &&
                      (hit_ff || free_ff) && (dur_ff != 16'd0);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_action != mste_pkg::ACT_NONE) begin
                  act_ff <= req_action;
                  tgt_ff <= req_target_id[TB-1:0];
                  sv_ff <= req_start_value;
                  ev_ff <= req_end_value;
                  dur_ff <= req_duration;
                  ease_ff <= req_ease_mode;
                  notify_ff <= req_notify_done;
                  snap_ff <= req_snap;
                  idx_ff <= '0;
                  hit_ff <= 1'b0;
                  free_ff <= 1'b0;
                  any_ff <= 1'b0;
                  hit_idx_ff <= '0;
                  free_idx_ff <= '0;
                  state_ff <= (req_action == mste_pkg::ACT_TICK) ? S_VISIT : S_SCAN;
               end
            end
            S_SCAN: begin
               // one slot per cycle: match and lowest free
               if (active_ff[slot] && tgt_mem[slot] == tgt_ff && !hit_ff) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= slot;
               end
               if (!active_ff[slot] && !free_ff) begin
                  free_ff <= 1'b1;
                  free_idx_ff <= slot;
               end
               if (last_slot) state_ff <= S_DIV;
               else idx_ff <= idx_ff + (IW+1)'(1);
            end
            S_DIV: begin
               // settle the start or cancel
               if (act_ff == mste_pkg::ACT_CANCEL) begin
                  if (out_free) begin
                     o_tgt_ff <= 8'(tgt_ff);
                     o_done_ff <= 1'b0;
                     o_last_ff <= 1'b1;
                     if (hit_ff) begin
                        active_ff[hit_idx_ff] <= 1'b0;
                        o_val_ff <= snap_ff ? end_mem[hit_idx_ff] : 32'd0;
                        o_wv_ff <= snap_ff;
                        o_slot_ff <= 4'(hit_idx_ff);
                        o_st_ff <= mste_pkg::ST_CANCELLED;
                     end else begin
                        o_val_ff <= '0;
                        o_wv_ff <= 1'b0;
                        o_slot_ff <= '0;
                        o_st_ff <= mste_pkg::ST_NOT_FOUND;
                     end
                     state_ff <= S_IDLE;
                  end
               end else if (!hit_ff && !free_ff) begin
                  if (out_free) begin
                     o_tgt_ff <= 8'(tgt_ff);
                     o_val_ff <= ev_ff;
                     o_wv_ff <= 1'b1;
                     o_done_ff <= 1'b0;
                     o_slot_ff <= '0;
                     o_st_ff <= mste_pkg::ST_NO_CAP;
                     o_last_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else begin
                  if (hit_ff) free_idx_ff <= hit_idx_ff;
                  if (dur_ff == 16'd0) begin
                     if (out_free) begin
                        if (hit_ff) active_ff[hit_idx_ff] <= 1'b0;
                        else active_ff[free_idx_ff] <= 1'b0;
                        o_tgt_ff <= 8'(tgt_ff);
                        o_val_ff <= ev_ff;
                        o_wv_ff <= 1'b1;
                        o_done_ff <= notify_ff;
                        o_slot_ff <= 4'(hit_ff ? hit_idx_ff : free_idx_ff);
                        o_st_ff <= mste_pkg::ST_IMMEDIATE;
                        o_last_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end
                  end else begin
                     state_ff <= S_WAIT;
                  end
               end
            end
            S_WAIT: begin
               if (drsp.done) begin
                  step_mem[free_idx_ff] <= drsp.quotient;
                  prog_mem[free_idx_ff] <= '0;
                  active_ff[free_idx_ff] <= 1'b1;
                  state_ff <= S_EMIT;
                  o_tgt_ff <= 8'(tgt_ff);
                  o_val_ff <= '0;
                  o_wv_ff <= 1'b0;
                  o_done_ff <= 1'b0;
                  o_slot_ff <= 4'(free_idx_ff);
                  o_st_ff <= mste_pkg::ST_STARTED;
                  o_last_ff <= 1'b1;
               end
            end
            S_VISIT: begin
               if (active_ff[slot]) begin
                  any_ff <= 1'b1;
                  p_ff <= ((18'(prog_mem[slot]) + 18'(step_mem[slot])) >=
                           18'(mste_pkg::ONE_Q16)) ? mste_pkg::ONE_Q16 :
                          prog_mem[slot] + step_mem[slot];
                  state_ff <= S_SQ;
               end else if (last_slot) begin
                  if (!any_ff) begin
                     o_tgt_ff <= '0;
                     o_val_ff <= '0;
                     o_wv_ff <= 1'b0;
                     o_done_ff <= 1'b0;
                     o_slot_ff <= '0;
                     o_st_ff <= mste_pkg::ST_TICK_IDLE;
                     o_last_ff <= 1'b1;
                     state_ff <= S_EMIT;
                  end else state_ff <= S_IDLE;
               end else idx_ff <= idx_ff + (IW+1)'(1);
            end
            S_SQ: begin
               // square for the quadratic ease
               e_ff <= ease_mem[slot] ? sq_q : p_ff;
               sq_hi_ff <= ease_mem[slot] && (p_ff > mste_pkg::HALF_Q16);
               prog_mem[slot] <= p_ff;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff <= $signed(delta_mem[slot]) *
                          $signed({15'd0, (ease_mem[slot] ? ease_v : e_ff)});
               state_ff <= S_ADD;
            end
            S_ADD: begin
               // wait until the previous result has been taken
               if (out_free) begin
                  o_tgt_ff <= 8'(tgt_mem[slot]);
                  o_wv_ff <= 1'b1;
                  o_slot_ff <= 4'(slot);
                  o_st_ff <= mste_pkg::ST_TICK_UPD;
                  if (p_ff == mste_pkg::ONE_Q16) begin
                     active_ff[slot] <= 1'b0;
                     o_val_ff <= end_mem[slot];
                     o_done_ff <= notify_mem[slot];
                  end else begin
                     o_val_ff <= start_mem[slot] + prod_ff[47:16];
                     o_done_ff <= 1'b0;
                  end
                  o_last_ff <= !later_act;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  if (o_last_ff || last_slot) state_ff <= S_IDLE;
                  else begin
                     idx_ff <= idx_ff + (IW+1)'(1);
                     state_ff <= S_VISIT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // write slot fields at start claim
   always_ff @(posedge clock) begin
      if (state_ff == S_DIV && act_ff == mste_pkg::ACT_START && (hit_ff || free_ff)) begin
         tgt_mem[hit_ff ? hit_idx_ff : free_idx_ff] <= tgt_ff;
         start_mem[hit_ff ? hit_idx_ff : free_idx_ff] <= sv_ff;
         end_mem[hit_ff ? hit_idx_ff : free_idx_ff] <= ev_ff;
         delta_mem[hit_ff ? hit_idx_ff : free_idx_ff] <= ev_ff - sv_ff;
         ease_mem[hit_ff ? hit_idx_ff : free_idx_ff] <= ease_ff;
         notify_mem[hit_ff ? hit_idx_ff : free_idx_ff] <= notify_ff;
      end
   end

   always_comb begin
      dreq.start = div_go_ff;
      dreq.dividend = mste_pkg::ONE_Q16 + {2'b00, dur_ff[15:1]};
      dreq.divisor = dur_ff;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out_target = o_tgt_ff;
   assign rsp_value = o_val_ff;
   assign rsp_write_valid = o_wv_ff;
   assign rsp_done_event = o_done_ff;
   assign rsp_slot_index = o_slot_ff;
   assign rsp_status = o_st_ff;
   assign rsp_last = o_last_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_value)) else $error("result changed");
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mste_pkg::ST_TICK_IDLE) |-> rsp_last)
      else $error("idle tick not last");
`endif
endmodule
`default_nettype wire
